// ----- rtl/core/p2p_rej_pkg.sv -----
package p2p_rej_pkg;

    // Channel count and field widths of the transaction payloads
    localparam int CHANNELS  = 64;
    localparam int SAMPLE_W  = 24;
    localparam int LIMIT_W   = 26;
    localparam int CH_W      = 6;
    localparam int KEPT_W    = 7;
    localparam int CFG_IDX_W = 2;
    localparam int MEAS_W    = SAMPLE_W + 1;
    localparam int CMP_W     = (MEAS_W > LIMIT_W) ? MEAS_W : LIMIT_W;

    localparam logic signed [LIMIT_W-1:0]  DEFAULT_LIMIT_RST = LIMIT_W'(3500);
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic [KEPT_W-1:0]          KEPT_SAT   = '1;
    localparam logic [CH_W-1:0]            CH_LAST    = CH_W'(CHANNELS - 1);

    typedef enum logic [0:0] {
        OP_SAMPLE   = 1'b0,
        OP_LIMIT_WR = 1'b1
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_ONLY      = 2'd0,
        CFG_CHANNEL_MODE  = 2'd1,
        CFG_INVERT        = 2'd2,
        CFG_DEFAULT_LIMIT = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic max_only;
        logic channel_mode;
        logic invert;
    } t_mode;

    typedef struct packed {
        logic                      en;
        logic [CH_W-1:0]           idx;
        logic signed [LIMIT_W-1:0] value;
    } t_lim_wr;

    typedef struct packed {
        logic [CH_W-1:0]            chan_id;
        logic                       channel_exceeded;
        logic                       channel_kept;
        logic signed [SAMPLE_W-1:0] channel_min;
        logic signed [SAMPLE_W-1:0] channel_max;
        logic                       epoch_done;
        logic                       epoch_rejected;
        logic [KEPT_W-1:0]          kept_count;
        logic [CH_W-1:0]            first_bad_channel;
        logic                       first_bad_valid;
    } t_result;

endpackage

// ----- rtl/core/p2p_rej_in_if.sv -----
interface p2p_rej_in_if;
    logic                                          valid;
    logic                                          ready;
    logic                                          opcode;
    logic signed [p2p_rej_pkg::SAMPLE_W-1:0]       sample_value;
    logic                                          last_in_channel;
    logic                                          last_in_epoch;
    logic [p2p_rej_pkg::CH_W-1:0]                  channel_index;
    logic signed [p2p_rej_pkg::LIMIT_W-1:0]        limit_value;

    modport source (
        output valid, opcode, sample_value, last_in_channel, last_in_epoch,
               channel_index, limit_value,
        input  ready
    );
    modport sink (
        input  valid, opcode, sample_value, last_in_channel, last_in_epoch,
               channel_index, limit_value,
        output ready
    );
endinterface

// ----- rtl/core/p2p_rej_out_if.sv -----
interface p2p_rej_out_if;
    logic                                       valid;
    logic                                       ready;
    logic [p2p_rej_pkg::CH_W-1:0]               chan_id;
    logic                                       channel_exceeded;
    logic                                       channel_kept;
    logic signed [p2p_rej_pkg::SAMPLE_W-1:0]    channel_min;
    logic signed [p2p_rej_pkg::SAMPLE_W-1:0]    channel_max;
    logic                                       epoch_done;
    logic                                       epoch_rejected;
    logic [p2p_rej_pkg::KEPT_W-1:0]             kept_count;
    logic [p2p_rej_pkg::CH_W-1:0]               first_bad_channel;
    logic                                       first_bad_valid;

    modport source (
        output valid, chan_id, channel_exceeded, channel_kept, channel_min,
               channel_max, epoch_done, epoch_rejected, kept_count,
               first_bad_channel, first_bad_valid,
        input  ready
    );
    modport sink (
        input  valid, chan_id, channel_exceeded, channel_kept, channel_min,
               channel_max, epoch_done, epoch_rejected, kept_count,
               first_bad_channel, first_bad_valid,
        output ready
    );
endinterface

// ----- rtl/core/p2p_rej_limits.sv -----
module p2p_rej_limits (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  p2p_rej_pkg::t_lim_wr                   i_wr,
    input  logic [p2p_rej_pkg::CH_W-1:0]           i_rd_idx,
    input  logic [p2p_rej_pkg::CH_W-1:0]           i_cur_idx,
    input  logic signed [p2p_rej_pkg::LIMIT_W-1:0] i_default_limit,
    output logic signed [p2p_rej_pkg::LIMIT_W-1:0] o_limit
);

    logic signed [p2p_rej_pkg::LIMIT_W-1:0] r_mem [p2p_rej_pkg::CHANNELS];
    logic signed [p2p_rej_pkg::LIMIT_W-1:0] r_rd_data;
    logic [p2p_rej_pkg::CHANNELS-1:0]       r_ovr_valid;

    // Read ahead at the next channel index; forward a same-cycle write.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.idx] <= i_wr.value;
        end
        if (i_wr.en && (i_wr.idx == i_rd_idx)) begin
            r_rd_data <= i_wr.value;
        end else begin
            r_rd_data <= r_mem[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovr_valid <= '0;
        end else if (i_wr.en) begin
            r_ovr_valid[i_wr.idx] <= 1'b1;
        end
    end

    assign o_limit = r_ovr_valid[i_cur_idx] ? r_rd_data : i_default_limit;

endmodule

// ----- rtl/core/p2p_rej_track.sv -----
module p2p_rej_track (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_fire,
    input  logic signed [p2p_rej_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                    i_last_ch,
    input  logic                                    i_last_ep,
    input  p2p_rej_pkg::t_mode                      i_mode,
    input  logic signed [p2p_rej_pkg::LIMIT_W-1:0]  i_limit,
    output logic [p2p_rej_pkg::CH_W-1:0]            o_cnt,
    output logic [p2p_rej_pkg::CH_W-1:0]            o_cnt_next,
    output p2p_rej_pkg::t_result                    o_result
);

    logic signed [p2p_rej_pkg::SAMPLE_W-1:0] r_min, n_min, r_max, n_max;
    logic [p2p_rej_pkg::CH_W-1:0]            r_cnt, n_cnt, r_first, n_first;
    logic [p2p_rej_pkg::KEPT_W-1:0]          r_kept, n_kept;
    logic                                    r_any, n_any;

    logic signed [p2p_rej_pkg::SAMPLE_W-1:0] cur_min, cur_max;
    logic signed [p2p_rej_pkg::MEAS_W-1:0]   measure;
    logic                                    exceeded, kept, any_upd, rejected;
    logic [p2p_rej_pkg::KEPT_W-1:0]          kept_upd;
    logic [p2p_rej_pkg::CH_W-1:0]            first_upd;

    always_comb begin
        cur_min   = (i_sample < r_min) ? i_sample : r_min;
        cur_max   = (i_sample > r_max) ? i_sample : r_max;
        measure   = i_mode.max_only ? p2p_rej_pkg::MEAS_W'(cur_max)
                  : p2p_rej_pkg::MEAS_W'(cur_max) - p2p_rej_pkg::MEAS_W'(cur_min);
        exceeded  = p2p_rej_pkg::CMP_W'(measure) > p2p_rej_pkg::CMP_W'(i_limit);
        kept      = ~exceeded ^ i_mode.invert;
        kept_upd  = (kept && (r_kept != p2p_rej_pkg::KEPT_SAT)) ? r_kept + 1'b1 : r_kept;
        any_upd   = r_any | exceeded;
        first_upd = (exceeded && !r_any) ? r_cnt : r_first;
        rejected  = i_last_ep & (i_mode.channel_mode ? (kept_upd == '0)
                                                     : (any_upd ^ i_mode.invert));

        o_result.chan_id           = r_cnt;
        o_result.channel_exceeded  = exceeded;
        o_result.channel_kept      = kept;
        o_result.channel_min       = cur_min;
        o_result.channel_max       = cur_max;
        o_result.epoch_done        = i_last_ep;
        o_result.epoch_rejected    = rejected;
        o_result.kept_count        = kept_upd;
        o_result.first_bad_channel = first_upd;
        o_result.first_bad_valid   = any_upd;

        n_min   = r_min;
        n_max   = r_max;
        n_cnt   = r_cnt;
        n_kept  = r_kept;
        n_first = r_first;
        n_any   = r_any;
        if (i_fire) begin
            if (i_last_ch || i_last_ep) begin
                n_min = p2p_rej_pkg::SAMPLE_MAX;
                n_max = p2p_rej_pkg::SAMPLE_MIN;
                if (i_last_ep) begin
                    n_cnt   = '0;
                    n_kept  = '0;
                    n_first = '0;
                    n_any   = 1'b0;
                end else begin
                    n_cnt   = (r_cnt == p2p_rej_pkg::CH_LAST) ? r_cnt : r_cnt + 1'b1;
                    n_kept  = kept_upd;
                    n_first = first_upd;
                    n_any   = any_upd;
                end
            end else begin
                n_min = cur_min;
                n_max = cur_max;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min   <= p2p_rej_pkg::SAMPLE_MAX;
            r_max   <= p2p_rej_pkg::SAMPLE_MIN;
            r_cnt   <= '0;
            r_kept  <= '0;
            r_first <= '0;
            r_any   <= 1'b0;
        end else begin
            r_min   <= n_min;
            r_max   <= n_max;
            r_cnt   <= n_cnt;
            r_kept  <= n_kept;
            r_first <= n_first;
            r_any   <= n_any;
        end
    end

    assign o_cnt      = r_cnt;
    assign o_cnt_next = n_cnt;

endmodule

// ----- rtl/core/peak_to_peak_epoch_reject_core.sv -----
// Peak-to-peak epoch rejection. Samples stream in channel by channel; the block
// keeps the running minimum and maximum of the current channel and, on the
// channel's last sample (or the epoch's last sample), compares max - min (or the
// maximum alone when max_only is set) strictly against the channel's limit: a
// per-channel override written with an opcode-1 transaction, else default_limit.
// One result transaction leaves per finished channel, carrying the verdict, keep
// bit, extremes and epoch bookkeeping; the one that closes the epoch also carries
// the epoch verdict. The block takes one transaction per clock cycle unless a
// closing sample is stalled. A transaction lands in an input register, is
// evaluated there and, if it closes a channel, loads the output register that
// drives result valid. The output register lets the next transaction enter
// while a result waits; only a channel-closing sample stalls behind an
// unconsumed result. Per-channel limits live in a 64-entry memory read ahead
// at the next channel index, so a limit write is seen by the very next sample.
// Write configuration only while idle.
module peak_to_peak_epoch_reject_core (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    p2p_rej_in_if.sink                             i_in,
    p2p_rej_out_if.source                          o_res,
    input  logic                                   i_cfg_we,
    input  logic [p2p_rej_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [p2p_rej_pkg::LIMIT_W-1:0]        i_cfg_data
);

    // Configuration registers
    p2p_rej_pkg::t_mode                     r_mode;
    logic signed [p2p_rej_pkg::LIMIT_W-1:0] r_default_limit;

    // Input stage
    logic                                    r_s1_valid;
    logic                                    r_s1_op;
    logic signed [p2p_rej_pkg::SAMPLE_W-1:0] r_s1_sample;
    logic                                    r_s1_last_ch;
    logic                                    r_s1_last_ep;
    logic [p2p_rej_pkg::CH_W-1:0]            r_s1_idx;
    logic signed [p2p_rej_pkg::LIMIT_W-1:0]  r_s1_limit;

    // Result stage
    logic                 r_out_valid;
    p2p_rej_pkg::t_result r_out;

    logic                                   s1_sample;
    logic                                   s1_result;
    logic                                   out_free;
    logic                                   s1_go;
    logic                                   in_ready;
    p2p_rej_pkg::t_lim_wr                   lim_wr;
    logic signed [p2p_rej_pkg::LIMIT_W-1:0] cur_limit;
    logic [p2p_rej_pkg::CH_W-1:0]           cur_cnt;
    logic [p2p_rej_pkg::CH_W-1:0]           next_cnt;
    p2p_rej_pkg::t_result                   result;

    // Configuration writes; indexes past the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= '0;
            r_default_limit <= p2p_rej_pkg::DEFAULT_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (p2p_rej_pkg::t_cfg_reg'(i_cfg_idx))
                p2p_rej_pkg::CFG_MAX_ONLY:      r_mode.max_only     <= i_cfg_data[0];
                p2p_rej_pkg::CFG_CHANNEL_MODE:  r_mode.channel_mode <= i_cfg_data[0];
                p2p_rej_pkg::CFG_INVERT:        r_mode.invert       <= i_cfg_data[0];
                p2p_rej_pkg::CFG_DEFAULT_LIMIT: r_default_limit     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake: a closing sample advances only if the result slot frees up.
    always_comb begin
        s1_sample = (r_s1_op == 1'(p2p_rej_pkg::OP_SAMPLE));
        s1_result = r_s1_valid && s1_sample && (r_s1_last_ch || r_s1_last_ep);
        out_free  = !r_out_valid || o_res.ready;
        s1_go     = r_s1_valid && (!s1_result || out_free);
        in_ready  = !r_s1_valid || s1_go;

        lim_wr.en    = s1_go && !s1_sample && (32'(r_s1_idx) < p2p_rej_pkg::CHANNELS);
        lim_wr.idx   = r_s1_idx;
        lim_wr.value = r_s1_limit;
    end

    assign i_in.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    // Hold the payload until the stage advances.
    always_ff @(posedge i_clk) begin
        if (in_ready && i_in.valid) begin
            r_s1_op      <= i_in.opcode;
            r_s1_sample  <= i_in.sample_value;
            r_s1_last_ch <= i_in.last_in_channel;
            r_s1_last_ep <= i_in.last_in_epoch;
            r_s1_idx     <= i_in.channel_index;
            r_s1_limit   <= i_in.limit_value;
        end
    end

    p2p_rej_limits u_limits (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_wr            (lim_wr),
        .i_rd_idx        (next_cnt),
        .i_cur_idx       (cur_cnt),
        .i_default_limit (r_default_limit),
        .o_limit         (cur_limit)
    );

    p2p_rej_track u_track (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (s1_go && s1_sample),
        .i_sample   (r_s1_sample),
        .i_last_ch  (r_s1_last_ch),
        .i_last_ep  (r_s1_last_ep),
        .i_mode     (r_mode),
        .i_limit    (cur_limit),
        .o_cnt      (cur_cnt),
        .o_cnt_next (next_cnt),
        .o_result   (result)
    );

    // Result register: load on a closing sample, drop once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && s1_result) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && s1_result) begin
            r_out <= result;
        end
    end

    assign o_res.valid             = r_out_valid;
    assign o_res.chan_id           = r_out.chan_id;
    assign o_res.channel_exceeded  = r_out.channel_exceeded;
    assign o_res.channel_kept      = r_out.channel_kept;
    assign o_res.channel_min       = r_out.channel_min;
    assign o_res.channel_max       = r_out.channel_max;
    assign o_res.epoch_done        = r_out.epoch_done;
    assign o_res.epoch_rejected    = r_out.epoch_rejected;
    assign o_res.kept_count        = r_out.kept_count;
    assign o_res.first_bad_channel = r_out.first_bad_channel;
    assign o_res.first_bad_valid   = r_out.first_bad_valid;

    a_reject_only_at_epoch_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.epoch_done |-> !r_out.epoch_rejected)
        else $error("epoch verdict set on a result that does not close the epoch");

    a_first_bad_zero_when_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.first_bad_valid |-> r_out.first_bad_channel == '0)
        else $error("first bad channel nonzero while no channel exceeded");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_result && r_out_valid && !o_res.ready |-> !i_in.ready)
        else $error("input accepted while a closing sample is stalled");

    a_epoch_end_clears_counter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_go && s1_sample && r_s1_last_ep |=> cur_cnt == '0)
        else $error("channel counter not cleared after epoch end");

endmodule

// ----- dv/peak_to_peak_epoch_reject_core_tb.sv -----
`timescale 1ns / 1ps

module peak_to_peak_epoch_reject_core_tb;
    import p2p_rej_pkg::*;

    // Guard against a hung handshake; the slowest legal run is far shorter
    localparam int CYCLE_LIMIT = 250000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        t_opcode                    op;
        logic signed [SAMPLE_W-1:0] smp;
        logic                       lch;
        logic                       lep;
        logic [CH_W-1:0]            idx;
        logic signed [LIMIT_W-1:0]  lim;
    } t_stim;

    logic i_clk;
    logic i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [LIMIT_W-1:0]   i_cfg_data;

    p2p_rej_in_if  in_if ();
    p2p_rej_out_if res_if ();

    peak_to_peak_epoch_reject_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_res      (res_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Stimulus waiting to be offered, and channel verdicts waiting to arrive
    t_stim   sample_stream[$];
    t_result verdict_queue[$];
    int      queued;
    int      mismatches;
    int      cycle_count;

    // Idling control: steady turns off random bursts on both sides
    bit steady;
    int send_gap;
    int take_gap;
    int hold_requests;
    int hold_seen;
    int hold_left;

    // Predictor copy of the registers and of the block state
    logic                       cfg_max_only;
    logic                       cfg_channel_mode;
    logic                       cfg_invert;
    logic signed [LIMIT_W-1:0]  cfg_default_limit;
    logic signed [SAMPLE_W-1:0] run_min;
    logic signed [SAMPLE_W-1:0] run_max;
    logic [CH_W-1:0]            ch_cnt;
    logic [KEPT_W-1:0]          kept_cnt;
    logic [CH_W-1:0]            first_bad;
    logic                       any_bad;
    logic signed [LIMIT_W-1:0]  ovr_limit [CHANNELS];
    bit                         ovr_set   [CHANNELS];

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Timeout watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor: advance the state by one accepted transaction and queue
    // the channel verdict when a channel (or the epoch) closes.
    // ------------------------------------------------------------------
    task automatic judge_transaction(t_stim t);
        t_result                   r;
        logic signed [LIMIT_W-1:0] ch_limit;
        int                        measure;
        logic                      exceeded;
        logic                      kept;

        // Override writes produce nothing and ignore the last flags
        if (t.op == OP_LIMIT_WR) begin
            ovr_limit[t.idx] = t.lim;
            ovr_set[t.idx]   = 1'b1;
            return;
        end
        if (t.smp > run_max) run_max = t.smp;
        if (t.smp < run_min) run_min = t.smp;
        // Epoch end closes the channel even without its own last flag
        if (!t.lch && !t.lep) return;

        ch_limit = ovr_set[ch_cnt] ? ovr_limit[ch_cnt] : cfg_default_limit;
        measure  = cfg_max_only ? int'(run_max) : int'(run_max) - int'(run_min);
        exceeded = (measure > int'(ch_limit));
        kept     = !exceeded ^ cfg_invert;

        if (kept && kept_cnt != KEPT_SAT) kept_cnt = kept_cnt + 1'b1;
        if (exceeded && !any_bad) begin
            any_bad   = 1'b1;
            first_bad = ch_cnt;
        end

        r.chan_id           = ch_cnt;
        r.channel_exceeded  = exceeded;
        r.channel_kept      = kept;
        r.channel_min       = run_min;
        r.channel_max       = run_max;
        r.epoch_done        = t.lep;
        r.epoch_rejected    = !t.lep ? 1'b0 :
                              cfg_channel_mode ? (kept_cnt == '0) : (any_bad ^ cfg_invert);
        r.kept_count        = kept_cnt;
        r.first_bad_channel = first_bad;
        r.first_bad_valid   = any_bad;
        verdict_queue.push_back(r);

        // Rearm the extremes; the channel counter sticks at the last entry
        run_min = SAMPLE_MAX;
        run_max = SAMPLE_MIN;
        if (ch_cnt != CH_LAST) ch_cnt = ch_cnt + 1'b1;
        if (t.lep) begin
            ch_cnt    = '0;
            kept_cnt  = '0;
            first_bad = '0;
            any_bad   = 1'b0;
        end
    endtask

    function automatic void check_field(string name, logic signed [63:0] want,
                                        logic signed [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Driver: offer the next pending transaction whenever the slot is free.
    // A burst gap is armed at issue time and runs once the item is taken.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_stim t;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            send_gap    <= 0;
        end else if (!in_if.valid || in_if.ready) begin
            if (send_gap != 0) begin
                send_gap    <= send_gap - 1;
                in_if.valid <= 1'b0;
            end else if (sample_stream.size() != 0) begin
                t = sample_stream.pop_front();
                in_if.valid           <= 1'b1;
                in_if.opcode          <= t.op;
                in_if.sample_value    <= t.smp;
                in_if.last_in_channel <= t.lch;
                in_if.last_in_epoch   <= t.lep;
                in_if.channel_index   <= t.idx;
                in_if.limit_value     <= t.lim;
                if (!steady && $urandom_range(0, 5) == 0)
                    send_gap <= $urandom_range(1, 9);
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted here; kicked by bumping hold_requests
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_seen <= 0;
            hold_left <= 0;
        end else if (hold_requests != hold_seen) begin
            hold_seen <= hold_requests;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver ready: random stall bursts, or the long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            take_gap     <= 0;
        end else if (hold_left != 0) begin
            res_if.ready <= 1'b0;
        end else if (take_gap != 0) begin
            take_gap     <= take_gap - 1;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
            if (!steady && $urandom_range(0, 5) == 0)
                take_gap <= $urandom_range(1, 9);
        end
    end

    // Monitor: predict on every accepted input, check every accepted result
    always @(posedge i_clk) begin
        t_stim   t;
        t_result want;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                t.op  = t_opcode'(in_if.opcode);
                t.smp = in_if.sample_value;
                t.lch = in_if.last_in_channel;
                t.lep = in_if.last_in_epoch;
                t.idx = in_if.channel_index;
                t.lim = in_if.limit_value;
                judge_transaction(t);
            end
            if (res_if.valid && res_if.ready) begin
                if (verdict_queue.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual chan_id %0d",
                             $time, res_if.chan_id);
                    mismatches++;
                end else begin
                    want = verdict_queue.pop_front();
                    check_field("chan_id", want.chan_id, res_if.chan_id);
                    check_field("channel_exceeded", want.channel_exceeded,
                                res_if.channel_exceeded);
                    check_field("channel_kept", want.channel_kept, res_if.channel_kept);
                    check_field("channel_min", want.channel_min, res_if.channel_min);
                    check_field("channel_max", want.channel_max, res_if.channel_max);
                    check_field("epoch_done", want.epoch_done, res_if.epoch_done);
                    check_field("epoch_rejected", want.epoch_rejected,
                                res_if.epoch_rejected);
                    check_field("kept_count", want.kept_count, res_if.kept_count);
                    check_field("first_bad_channel", want.first_bad_channel,
                                res_if.first_bad_channel);
                    check_field("first_bad_valid", want.first_bad_valid,
                                res_if.first_bad_valid);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    function automatic logic signed [SAMPLE_W-1:0] rand_sample(int amp);
        // Zero amplitude means the whole sample range
        if (amp == 0) return SAMPLE_W'($urandom);
        return SAMPLE_W'(int'($urandom_range(0, 2 * amp)) - amp);
    endfunction

    function automatic logic signed [LIMIT_W-1:0] rand_limit();
        case ($urandom_range(0, 4))
            0, 1:    return LIMIT_W'($urandom_range(0, 8000));
            2:       return LIMIT_W'(int'($urandom_range(0, 4000)) - 2000);
            3:       return LIMIT_W'(int'($urandom_range(0, 50331647)) - 16777216);
            default: return $urandom_range(0, 1) ? LIMIT_W'(33554431) : LIMIT_W'(-16777216);
        endcase
    endfunction

    function automatic int pick_amplitude();
        case ($urandom_range(0, 5))
            0:       return 30;
            1:       return 1500;
            2:       return 1800;
            3:       return 4000;
            4:       return 8388607;
            default: return 0;
        endcase
    endfunction

    task automatic push_sample(logic signed [SAMPLE_W-1:0] smp, logic lch, logic lep);
        t_stim t;
        t.op  = OP_SAMPLE;
        t.smp = smp;
        t.lch = lch;
        t.lep = lep;
        // Ignored on samples, but toggle them anyway
        t.idx = CH_W'($urandom);
        t.lim = rand_limit();
        sample_stream.push_back(t);
        queued++;
    endtask

    task automatic push_override(logic [CH_W-1:0] idx, logic signed [LIMIT_W-1:0] lim);
        t_stim t;
        t.op  = OP_LIMIT_WR;
        t.smp = SAMPLE_W'($urandom);
        t.lch = 1'($urandom_range(0, 1));
        t.lep = 1'($urandom_range(0, 1));
        t.idx = idx;
        t.lim = lim;
        sample_stream.push_back(t);
        queued++;
    endtask

    // Well-formed epoch with random content and sparse override writes
    task automatic gen_epoch(int n_ch, int max_len);
        int amp;
        int len;
        for (int c = 0; c < n_ch; c++) begin
            amp = pick_amplitude();
            len = $urandom_range(1, max_len);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 11) == 0)
                    push_override(CH_W'($urandom_range(0, 1) ? $urandom_range(0, 7)
                                                             : $urandom),
                                  rand_limit());
                if (c == n_ch - 1 && k == len - 1)
                    push_sample(rand_sample(amp), 1'($urandom_range(0, 1)), 1'b1);
                else
                    push_sample(rand_sample(amp), k == len - 1, 1'b0);
            end
        end
    endtask

    task automatic run_random(int n_items);
        t_stim t;
        int    stop_at;
        stop_at = queued + n_items;
        while (queued < stop_at) begin
            if ($urandom_range(0, 9) == 0) begin
                // Raw noise: every field random, flags in any combination
                t.op  = t_opcode'($urandom_range(0, 1));
                t.smp = SAMPLE_W'($urandom);
                t.lch = 1'($urandom_range(0, 1));
                t.lep = 1'($urandom_range(0, 1));
                t.idx = CH_W'($urandom);
                t.lim = rand_limit();
                sample_stream.push_back(t);
                queued++;
            end else begin
                gen_epoch($urandom_range(1, 8), $urandom_range(1, 6));
            end
        end
    endtask

    // Write one register; the predictor copy is updated when the write is driven
    task automatic write_reg(t_cfg_reg reg_idx, logic [LIMIT_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= reg_idx;
        i_cfg_data <= value;
        case (reg_idx)
            CFG_MAX_ONLY:      cfg_max_only      = value[0];
            CFG_CHANNEL_MODE:  cfg_channel_mode  = value[0];
            CFG_INVERT:        cfg_invert        = value[0];
            CFG_DEFAULT_LIMIT: cfg_default_limit = value;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_mode(logic mo, logic cm, logic inv, logic signed [LIMIT_W-1:0] dl);
        write_reg(CFG_MAX_ONLY, LIMIT_W'(mo));
        write_reg(CFG_CHANNEL_MODE, LIMIT_W'(cm));
        write_reg(CFG_INVERT, LIMIT_W'(inv));
        write_reg(CFG_DEFAULT_LIMIT, dl);
    endtask

    // Wait until every transaction is taken and every verdict has arrived,
    // then let the pipeline settle
    task automatic wait_drained();
        @(negedge i_clk);
        while (sample_stream.size() != 0 || in_if.valid || verdict_queue.size() != 0)
            @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    initial begin
        // Known values on every input from time zero
        i_rst_n               = 1'b0;
        i_cfg_we              = 1'b0;
        i_cfg_idx             = CFG_MAX_ONLY;
        i_cfg_data            = '0;
        in_if.valid           = 1'b0;
        in_if.opcode          = OP_SAMPLE;
        in_if.sample_value    = '0;
        in_if.last_in_channel = 1'b0;
        in_if.last_in_epoch   = 1'b0;
        in_if.channel_index   = '0;
        in_if.limit_value     = '0;
        res_if.ready          = 1'b0;

        // Predictor state matches the block after reset
        cfg_max_only      = 1'b0;
        cfg_channel_mode  = 1'b0;
        cfg_invert        = 1'b0;
        cfg_default_limit = DEFAULT_LIMIT_RST;
        run_min           = SAMPLE_MAX;
        run_max           = SAMPLE_MIN;
        ch_cnt            = '0;
        kept_cnt          = '0;
        first_bad         = '0;
        any_bad           = 1'b0;
        for (int i = 0; i < CHANNELS; i++) begin
            ovr_limit[i] = '0;
            ovr_set[i]   = 1'b0;
        end
        queued        = 0;
        mismatches    = 0;
        cycle_count   = 0;
        steady        = 1'b0;
        hold_requests = 0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part under reset settings
        push_sample(SAMPLE_MAX, 1'b0, 1'b0);      // full-scale swing, exceeds
        push_sample(SAMPLE_MIN, 1'b1, 1'b0);
        push_sample('0, 1'b1, 1'b0);              // one-sample channel, zero swing
        push_override(CH_LAST, LIMIT_W'(33554431)); // override with random last flags
        push_override('0, LIMIT_W'(-16777216));
        push_override(6'd2, 3000);
        push_sample(100, 1'b0, 1'b0);
        push_sample(3100, 1'b0, 1'b1);            // epoch end without channel end
        push_sample(-5, 1'b1, 1'b0);              // channel 0 override: lowest limit
        push_sample(3400, 1'b0, 1'b0);
        push_sample(-100, 1'b1, 1'b0);            // swing 3500 equals limit: kept
        push_sample(-3001, 1'b0, 1'b0);
        push_sample(0, 1'b1, 1'b1);               // channel 2 override, swing 3001
        push_sample(SAMPLE_MIN, 1'b1, 1'b1);      // one-channel epoch at the floor
        push_sample(SAMPLE_MAX, 1'b1, 1'b1);
        run_random(200);
        wait_drained();

        // Max alone against the lowest default; long epoch saturates the
        // channel counter
        set_mode(1'b1, 1'b0, 1'b0, -16777216);
        gen_epoch(140, 1);
        run_random(100);
        wait_drained();

        set_mode(1'b0, 1'b1, 1'b1, 33554431);
        run_random(150);
        wait_drained();

        // Hold the receiver off while the sender keeps offering
        set_mode(1'b1, 1'b1, 1'b0, '0);
        hold_requests++;
        run_random(150);
        wait_drained();

        set_mode(1'b0, 1'b0, 1'b1, 2000);
        run_random(150);
        wait_drained();

        // No idling in the last part; long kept epoch saturates the kept count
        steady = 1'b1;
        set_mode(1'b0, 1'b1, 1'b0, DEFAULT_LIMIT_RST);
        for (int i = 0; i < CHANNELS; i++)
            push_override(CH_W'(i), 4000);
        gen_epoch(140, 1);
        run_random(100);
        wait_drained();
        repeat (10) @(negedge i_clk);

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/p2p_rej_pkg.sv
rtl/core/p2p_rej_in_if.sv
rtl/core/p2p_rej_out_if.sv
rtl/core/p2p_rej_limits.sv
rtl/core/p2p_rej_track.sv
rtl/core/peak_to_peak_epoch_reject_core.sv
dv/peak_to_peak_epoch_reject_core_tb.sv
